/* src/cgms_pkg.sv */
`timescale 1ns / 1ps

package cgms_pkg;

	// request kinds
	localparam logic REQ_ADVANCE = 1'b0;
	localparam logic REQ_LOAD    = 1'b1;

	// contact side bit positions
	localparam int SIDE_TOP    = 0;
	localparam int SIDE_BOTTOM = 1;
	localparam int SIDE_LEFT   = 2;
	localparam int SIDE_RIGHT  = 3;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRICTION_X   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRICTION_Y   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRAVITY      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FALL_GRAVITY = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_X      = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_Y      = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_TERMINAL_X   = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_TERMINAL_Y   = 3'd7;

	// field widths fixed by the interface
	localparam int CFG_DATA_BITS = 21;
	localparam int FRIC_BITS     = 20;
	localparam int TERM_BITS     = 20;
	localparam int ACC_BITS      = 21;
	localparam int IO_POS_BITS   = 32;
	localparam int IO_VEL_BITS   = 21;

	localparam logic [TERM_BITS-1:0] TERMINAL_RESET = 20'hFFFFF;

	typedef struct packed {
		logic [FRIC_BITS-1:0]       friction_x;
		logic [FRIC_BITS-1:0]       friction_y;
		logic signed [ACC_BITS-1:0] gravity;
		logic signed [ACC_BITS-1:0] fall_gravity;
		logic signed [ACC_BITS-1:0] accel_x;
		logic signed [ACC_BITS-1:0] accel_y;
		logic [TERM_BITS-1:0]       terminal_x;
		logic [TERM_BITS-1:0]       terminal_y;
	} cfg_t;

	typedef struct packed {
		logic                          req_type;
		logic [3:0]                    plat_sides;
		logic [3:0]                    obj_sides;
		logic signed [IO_POS_BITS-1:0] load_pos_x;
		logic signed [IO_POS_BITS-1:0] load_pos_y;
		logic signed [IO_VEL_BITS-1:0] load_vel_x;
		logic signed [IO_VEL_BITS-1:0] load_vel_y;
	} req_t;

endpackage

/* src/cgms_if.sv */
`timescale 1ns / 1ps

// request channel
interface cgms_req_if import cgms_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [3:0]                    plat_sides;
	logic [3:0]                    obj_sides;
	logic signed [IO_POS_BITS-1:0] load_pos_x;
	logic signed [IO_POS_BITS-1:0] load_pos_y;
	logic signed [IO_VEL_BITS-1:0] load_vel_x;
	logic signed [IO_VEL_BITS-1:0] load_vel_y;

	modport source (
		output valid, req_type, plat_sides, obj_sides,
		output load_pos_x, load_pos_y, load_vel_x, load_vel_y,
		input  ready
	);
	modport sink (
		input  valid, req_type, plat_sides, obj_sides,
		input  load_pos_x, load_pos_y, load_vel_x, load_vel_y,
		output ready
	);
endinterface

// result channel
interface cgms_res_if import cgms_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [IO_POS_BITS-1:0] pos_x;
	logic signed [IO_POS_BITS-1:0] pos_y;
	logic signed [IO_VEL_BITS-1:0] vel_x;
	logic signed [IO_VEL_BITS-1:0] vel_y;

	modport source (
		output valid, pos_x, pos_y, vel_x, vel_y,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, vel_x, vel_y,
		output ready
	);
endinterface

/* src/cgms_cfg_regs.sv */
`timescale 1ns / 1ps

module cgms_cfg_regs import cgms_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	// register writes, masked to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.friction_x   <= '0;
			cfg_q.friction_y   <= '0;
			cfg_q.gravity      <= '0;
			cfg_q.fall_gravity <= '0;
			cfg_q.accel_x      <= '0;
			cfg_q.accel_y      <= '0;
			cfg_q.terminal_x   <= TERMINAL_RESET;
			cfg_q.terminal_y   <= TERMINAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRICTION_X:   cfg_q.friction_x   <= cfg_data[FRIC_BITS-1:0];
				REG_FRICTION_Y:   cfg_q.friction_y   <= cfg_data[FRIC_BITS-1:0];
				REG_GRAVITY:      cfg_q.gravity      <= $signed(cfg_data[ACC_BITS-1:0]);
				REG_FALL_GRAVITY: cfg_q.fall_gravity <= $signed(cfg_data[ACC_BITS-1:0]);
				REG_ACCEL_X:      cfg_q.accel_x      <= $signed(cfg_data[ACC_BITS-1:0]);
				REG_ACCEL_Y:      cfg_q.accel_y      <= $signed(cfg_data[ACC_BITS-1:0]);
				REG_TERMINAL_X:   cfg_q.terminal_x   <= cfg_data[TERM_BITS-1:0];
				REG_TERMINAL_Y:   cfg_q.terminal_y   <= cfg_data[TERM_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/cgms_step.sv */
`timescale 1ns / 1ps

module cgms_step import cgms_pkg::*; #(
	parameter int POS_BITS = 32,
	parameter int VEL_BITS = 21
) (
	input  req_t                       item,
	input  cfg_t                       cfg,
	input  logic [POS_BITS-1:0]        pos_x,
	input  logic [POS_BITS-1:0]        pos_y,
	input  logic signed [VEL_BITS-1:0] vel_x,
	input  logic signed [VEL_BITS-1:0] vel_y,
	output logic [POS_BITS-1:0]        pos_x_n,
	output logic [POS_BITS-1:0]        pos_y_n,
	output logic signed [VEL_BITS-1:0] vel_x_n,
	output logic signed [VEL_BITS-1:0] vel_y_n
);

	// working width: the wider of velocity and acceleration plus three guard bits
	localparam int WW = ((VEL_BITS > ACC_BITS) ? VEL_BITS : ACC_BITS) + 3;
	localparam int EW = (POS_BITS > VEL_BITS) ? POS_BITS : VEL_BITS;
	localparam logic signed [WW-1:0] VMAX = WW'((64'd1 << (VEL_BITS - 1)) - 64'd1);

	function automatic logic signed [WW-1:0] toward_zero(
		input logic signed [WW-1:0] v,
		input logic signed [WW-1:0] f
	);
		logic signed [WW-1:0] d;
		logic signed [WW-1:0] s;
		d = v - f;
		s = v + f;
		if (v > 0)
			toward_zero = (d > 0) ? d : '0;
		else
			toward_zero = (s < 0) ? s : '0;
	endfunction

	function automatic logic signed [WW-1:0] clamp_sym(
		input logic signed [WW-1:0] v,
		input logic signed [WW-1:0] lim
	);
		if (v < -lim)
			clamp_sym = -lim;
		else if (v > lim)
			clamp_sym = lim;
		else
			clamp_sym = v;
	endfunction

	function automatic logic allowed(
		input logic                 neg_blocked,
		input logic                 pos_blocked,
		input logic signed [WW-1:0] amount
	);
		allowed = (!neg_blocked && amount < 0) || (!pos_blocked && amount > 0);
	endfunction

	logic [3:0]           any_sides;
	logic [3:0]           ps;
	logic signed [WW-1:0] fx_w, fy_w, g_w, fg_w, ax_w, ay_w;
	logic signed [WW-1:0] tx_w, ty_w, lim_x, lim_y;
	logic signed [WW-1:0] vx_f, vy_f, vx_a, vy_g, vy_a, vx_c, vy_c;
	logic signed [WW-1:0] ld_vx, ld_vy;
	logic signed [VEL_BITS-1:0] vx_new, vy_new;
	logic [EW-1:0]        sum_x, sum_y;

	// operands widened to the working width
	always_comb begin
		ps        = item.plat_sides;
		any_sides = item.plat_sides | item.obj_sides;
		fx_w  = $signed({{(WW-FRIC_BITS){1'b0}}, cfg.friction_x});
		fy_w  = $signed({{(WW-FRIC_BITS){1'b0}}, cfg.friction_y});
		tx_w  = $signed({{(WW-TERM_BITS){1'b0}}, cfg.terminal_x});
		ty_w  = $signed({{(WW-TERM_BITS){1'b0}}, cfg.terminal_y});
		g_w   = WW'(cfg.gravity);
		fg_w  = WW'(cfg.fall_gravity);
		ax_w  = WW'(cfg.accel_x);
		ay_w  = WW'(cfg.accel_y);
		lim_x = (tx_w > VMAX) ? VMAX : tx_w;
		lim_y = (ty_w > VMAX) ? VMAX : ty_w;
	end

	// friction, gravity, acceleration, terminal clamp
	always_comb begin
		vx_f = WW'(vel_x);
		vy_f = WW'(vel_y);
		if (any_sides[SIDE_TOP] || any_sides[SIDE_BOTTOM])
			vx_f = toward_zero(WW'(vel_x), fx_w);
		if (any_sides[SIDE_LEFT] || any_sides[SIDE_RIGHT])
			vy_f = toward_zero(WW'(vel_y), fy_w);

		vy_g = vy_f;
		if (fg_w > 0 && vy_f > 0) begin
			if (!ps[SIDE_BOTTOM])
				vy_g = vy_f + fg_w;
		end else if (allowed(ps[SIDE_TOP], ps[SIDE_BOTTOM], g_w)) begin
			vy_g = vy_f + g_w;
		end

		vx_a = allowed(ps[SIDE_LEFT], ps[SIDE_RIGHT], ax_w) ? vx_f + ax_w : vx_f;
		vy_a = allowed(ps[SIDE_TOP], ps[SIDE_BOTTOM], ay_w) ? vy_g + ay_w : vy_g;

		vx_c   = clamp_sym(vx_a, lim_x);
		vy_c   = clamp_sym(vy_a, lim_y);
		vx_new = vx_c[VEL_BITS-1:0];
		vy_new = vy_c[VEL_BITS-1:0];
	end

	// wrapping position add
	always_comb begin
		sum_x = EW'(pos_x) + EW'(vx_new);
		sum_y = EW'(pos_y) + EW'(vy_new);
	end

	// load words saturate velocity to the symmetric range -VMAX..VMAX
	always_comb begin
		ld_vx = clamp_sym(WW'(item.load_vel_x), VMAX);
		ld_vy = clamp_sym(WW'(item.load_vel_y), VMAX);
	end

	// select between load and advance
	always_comb begin
		if (item.req_type == REQ_LOAD) begin
			pos_x_n = POS_BITS'(item.load_pos_x);
			pos_y_n = POS_BITS'(item.load_pos_y);
			vel_x_n = ld_vx[VEL_BITS-1:0];
			vel_y_n = ld_vy[VEL_BITS-1:0];
		end else begin
			pos_x_n = sum_x[POS_BITS-1:0];
			pos_y_n = sum_y[POS_BITS-1:0];
			vel_x_n = vx_new;
			vel_y_n = vy_new;
		end
	end

endmodule

/* src/contact_gated_motion_step_top.sv */
`timescale 1ns / 1ps

// path: request words pass the input register, then the result register, to res
// throughput: one word per cycle unless res stalls; the state update is a single
// adder/clamp pass from the input register to the result and state registers
// reset: position and velocity clear to zero, terminal speeds to full scale,
// other configuration registers to zero, both channels empty

module contact_gated_motion_step_top import cgms_pkg::*; #(
	parameter int POS_BITS = 32,
	parameter int VEL_BITS = 21
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	cgms_req_if.sink                 req,
	cgms_res_if.source               res
);

	cfg_t                       cfg;
	req_t                       item_s1;
	logic                       valid_s1;
	logic                       res_valid_q;
	logic                       advance;
	logic [POS_BITS-1:0]        pos_x_q, pos_y_q, pos_x_n, pos_y_n;
	logic signed [VEL_BITS-1:0] vel_x_q, vel_y_q, vel_x_n, vel_y_n;
	logic [IO_POS_BITS-1:0]     res_pos_x_q, res_pos_y_q;
	logic [IO_VEL_BITS-1:0]     res_vel_x_q, res_vel_y_q;

	cgms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cgms_step #(
		.POS_BITS (POS_BITS),
		.VEL_BITS (VEL_BITS)
	) u_step (
		.item    (item_s1),
		.cfg     (cfg),
		.pos_x   (pos_x_q),
		.pos_y   (pos_y_q),
		.vel_x   (vel_x_q),
		.vel_y   (vel_y_q),
		.pos_x_n (pos_x_n),
		.pos_y_n (pos_y_n),
		.vel_x_n (vel_x_n),
		.vel_y_n (vel_y_n)
	);

	// handshake: the stage-one word moves on when the result slot is free or draining
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type   <= req.req_type;
			item_s1.plat_sides <= req.plat_sides;
			item_s1.obj_sides  <= req.obj_sides;
			item_s1.load_pos_x <= req.load_pos_x;
			item_s1.load_pos_y <= req.load_pos_y;
			item_s1.load_vel_x <= req.load_vel_x;
			item_s1.load_vel_y <= req.load_vel_y;
		end
	end

	// body state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
		end else if (advance) begin
			pos_x_q <= pos_x_n;
			pos_y_q <= pos_y_n;
			vel_x_q <= vel_x_n;
			vel_y_q <= vel_y_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_pos_x_q <= IO_POS_BITS'(pos_x_n);
			res_pos_y_q <= IO_POS_BITS'(pos_y_n);
			res_vel_x_q <= IO_VEL_BITS'(vel_x_n);
			res_vel_y_q <= IO_VEL_BITS'(vel_y_n);
		end
	end

	assign res.valid = res_valid_q;
	assign res.pos_x = $signed(res_pos_x_q);
	assign res.pos_y = $signed(res_pos_y_q);
	assign res.vel_x = $signed(res_vel_x_q);
	assign res.vel_y = $signed(res_vel_y_q);

endmodule

/* dv/contact_gated_motion_step_top_tb.sv */
`timescale 1ns / 1ps

module contact_gated_motion_step_top_tb;
	import cgms_pkg::*;

	localparam longint VEL_LIMIT   = (longint'(1) << (IO_VEL_BITS - 1)) - 1;
	localparam int     QUIET_LIMIT = 4000;
	localparam int     PRINT_LIMIT = 40;

	// one result word: the body state after a request word
	typedef struct packed {
		logic [IO_POS_BITS-1:0] pos_x;
		logic [IO_POS_BITS-1:0] pos_y;
		logic [IO_VEL_BITS-1:0] vel_x;
		logic [IO_VEL_BITS-1:0] vel_y;
	} body_state_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	cgms_req_if req_ch ();
	cgms_res_if res_ch ();

	contact_gated_motion_step_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	// predictor state and register shadow
	cfg_t                   motion_cfg;
	logic [IO_POS_BITS-1:0] body_pos_x;
	logic [IO_POS_BITS-1:0] body_pos_y;
	longint                 body_vel_x;
	longint                 body_vel_y;
	body_state_t            pending_states[$];

	int mismatches;
	int words_sent;
	int loads_sent;
	int results_checked;
	int settings_applied;
	bit no_idle;
	int sink_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic cfg_t reset_motion_cfg();
		cfg_t c;
		c            = '0;
		c.terminal_x = TERMINAL_RESET;
		c.terminal_y = TERMINAL_RESET;
		return c;
	endfunction

	function automatic longint toward_zero(longint v, longint f);
		if (v > 0)
			return (v - f > 0) ? v - f : 0;
		return (v + f < 0) ? v + f : 0;
	endfunction

	function automatic longint clamp_speed(longint v, longint lim);
		if (v < -lim)
			return -lim;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// a push is allowed when the side it points at has no platform contact
	function automatic bit side_free(logic [3:0] ps, longint amount, int neg_side, int pos_side);
		return (!ps[neg_side] && amount < 0) || (!ps[pos_side] && amount > 0);
	endfunction

	// one step of the body: load or advance, returns the state after it
	function automatic body_state_t advance_body(req_t w);
		longint      vx, vy, g, fg, ax, ay, tx, ty;
		logic [3:0]  any_side;
		body_state_t r;
		if (w.req_type == REQ_LOAD) begin
			body_pos_x = w.load_pos_x;
			body_pos_y = w.load_pos_y;
			body_vel_x = clamp_speed($signed(w.load_vel_x), VEL_LIMIT);
			body_vel_y = clamp_speed($signed(w.load_vel_y), VEL_LIMIT);
		end else begin
			any_side = w.plat_sides | w.obj_sides;
			vx = body_vel_x;
			vy = body_vel_y;
			g  = $signed(motion_cfg.gravity);
			fg = $signed(motion_cfg.fall_gravity);
			ax = $signed(motion_cfg.accel_x);
			ay = $signed(motion_cfg.accel_y);
			tx = motion_cfg.terminal_x;
			ty = motion_cfg.terminal_y;

			// friction from contact across each axis
			if (any_side[SIDE_TOP] || any_side[SIDE_BOTTOM])
				vx = toward_zero(vx, longint'(motion_cfg.friction_x));
			if (any_side[SIDE_LEFT] || any_side[SIDE_RIGHT])
				vy = toward_zero(vy, longint'(motion_cfg.friction_y));

			// moving down, fg > 0: fall gravity unless platform below, else gravity if free
			if (fg > 0 && vy > 0) begin
				if (!w.plat_sides[SIDE_BOTTOM])
					vy += fg;
			end else if (side_free(w.plat_sides, g, SIDE_TOP, SIDE_BOTTOM)) begin
				vy += g;
			end

			if (side_free(w.plat_sides, ax, SIDE_LEFT, SIDE_RIGHT))
				vx += ax;
			if (side_free(w.plat_sides, ay, SIDE_TOP, SIDE_BOTTOM))
				vy += ay;

			// terminal clamp, then integrate with wrap
			if (tx > VEL_LIMIT)
				tx = VEL_LIMIT;
			if (ty > VEL_LIMIT)
				ty = VEL_LIMIT;
			body_vel_x = clamp_speed(vx, tx);
			body_vel_y = clamp_speed(vy, ty);
			body_pos_x = body_pos_x + IO_POS_BITS'(body_vel_x);
			body_pos_y = body_pos_y + IO_POS_BITS'(body_vel_y);
		end
		r.pos_x = body_pos_x;
		r.pos_y = body_pos_y;
		r.vel_x = IO_VEL_BITS'(body_vel_x);
		r.vel_y = IO_VEL_BITS'(body_vel_y);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// compare a result word with the oldest expected state
	task automatic check_result();
		body_state_t want;
		if (pending_states.size() == 0) begin
			report_mismatch("result word with no request outstanding");
		end else begin
			want = pending_states.pop_front();
			if (res_ch.pos_x !== want.pos_x)
				report_mismatch($sformatf("pos_x got %0d expected %0d", res_ch.pos_x,
					$signed(want.pos_x)));
			if (res_ch.pos_y !== want.pos_y)
				report_mismatch($sformatf("pos_y got %0d expected %0d", res_ch.pos_y,
					$signed(want.pos_y)));
			if (res_ch.vel_x !== want.vel_x)
				report_mismatch($sformatf("vel_x got %0d expected %0d", res_ch.vel_x,
					$signed(want.vel_x)));
			if (res_ch.vel_y !== want.vel_y)
				report_mismatch($sformatf("vel_y got %0d expected %0d", res_ch.vel_y,
					$signed(want.vel_y)));
		end
		results_checked++;
	endtask

	// sample both channels at the rising edge
	always @(posedge clk) begin : monitor
		req_t seen;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				check_result();
			if (req_ch.valid && req_ch.ready) begin
				seen.req_type   = req_ch.req_type;
				seen.plat_sides = req_ch.plat_sides;
				seen.obj_sides  = req_ch.obj_sides;
				seen.load_pos_x = req_ch.load_pos_x;
				seen.load_pos_y = req_ch.load_pos_y;
				seen.load_vel_x = req_ch.load_vel_x;
				seen.load_vel_y = req_ch.load_vel_y;
				pending_states.push_back(advance_body(seen));
			end
		end
	end

	// result sink: random stalls, or a long hold when asked
	initial begin : result_sink
		int stall;
		res_ch.ready = 1'b0;
		forever begin
			if (sink_hold > 0) begin
				stall     = sink_hold;
				sink_hold = 0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 4);
			end
			repeat (stall) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
			end
			@(negedge clk);
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// watchdog on cycles with no word moving on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		do begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end while (quiet < QUIET_LIMIT);
		$display("[%0t] no progress for %0d cycles", $time, QUIET_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_word(input req_t w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= w.req_type;
		req_ch.plat_sides <= w.plat_sides;
		req_ch.obj_sides  <= w.obj_sides;
		req_ch.load_pos_x <= w.load_pos_x;
		req_ch.load_pos_y <= w.load_pos_y;
		req_ch.load_vel_x <= w.load_vel_x;
		req_ch.load_vel_y <= w.load_vel_y;
		do @(posedge clk); while (!req_ch.ready);
		words_sent++;
		if (w.req_type == REQ_LOAD)
			loads_sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (pending_states.size() == 0);
	endtask

	// write all eight registers while the block is idle
	task automatic set_motion_cfg(input cfg_t c);
		logic [CFG_IDX_BITS-1:0]  idx[8];
		logic [CFG_DATA_BITS-1:0] val[8];
		idx[0] = REG_FRICTION_X;   val[0] = CFG_DATA_BITS'(c.friction_x);
		idx[1] = REG_FRICTION_Y;   val[1] = CFG_DATA_BITS'(c.friction_y);
		idx[2] = REG_GRAVITY;      val[2] = c.gravity;
		idx[3] = REG_FALL_GRAVITY; val[3] = c.fall_gravity;
		idx[4] = REG_ACCEL_X;      val[4] = c.accel_x;
		idx[5] = REG_ACCEL_Y;      val[5] = c.accel_y;
		idx[6] = REG_TERMINAL_X;   val[6] = CFG_DATA_BITS'(c.terminal_x);
		idx[7] = REG_TERMINAL_Y;   val[7] = CFG_DATA_BITS'(c.terminal_y);
		for (int i = 0; i < 8; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		motion_cfg = c;
		settings_applied++;
	endtask

	function automatic req_t load_word(logic [31:0] px, logic [31:0] py,
			logic [20:0] vx, logic [20:0] vy);
		req_t w;
		w            = '0;
		w.req_type   = REQ_LOAD;
		w.load_pos_x = px;
		w.load_pos_y = py;
		w.load_vel_x = vx;
		w.load_vel_y = vy;
		return w;
	endfunction

	function automatic req_t tick_word(logic [3:0] ps, logic [3:0] os);
		req_t w;
		w            = '0;
		w.req_type   = REQ_ADVANCE;
		w.plat_sides = ps;
		w.obj_sides  = os;
		return w;
	endfunction

	function automatic logic [19:0] pick_u20();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 20'hFFFFF;
			2: return 20'($urandom_range(0, 3000));
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic logic [20:0] pick_s21();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 21'h0FFFFF;
			2: return 21'h100000;
			3: return 21'(int'($urandom_range(0, 4000)) - 2000);
			default: return 21'($urandom);
		endcase
	endfunction

	// random word: mostly ticks with sparse contact, some loads, fields always noisy
	function automatic req_t random_word();
		req_t w;
		w.req_type   = ($urandom_range(0, 9) == 0) ? REQ_LOAD : REQ_ADVANCE;
		w.plat_sides = $urandom_range(0, 1) ? 4'h0 : 4'($urandom);
		w.obj_sides  = $urandom_range(0, 1) ? 4'h0 : 4'($urandom);
		w.load_pos_x = $urandom;
		w.load_pos_y = $urandom;
		if ($urandom_range(0, 2) == 0) begin
			w.load_vel_x = 21'(int'($urandom_range(0, 4000)) - 2000);
			w.load_vel_y = 21'(int'($urandom_range(0, 4000)) - 2000);
		end else begin
			w.load_vel_x = 21'($urandom);
			w.load_vel_y = 21'($urandom);
		end
		return w;
	endfunction

	// loads at the field extremes and position wrap, reset settings
	task automatic test_load_and_wrap();
		send_word(tick_word(4'h0, 4'h0));
		send_word(load_word(32'h7FFFFFFF, 32'h80000000, 21'h0FFFFF, 21'h100000));
		send_word(tick_word(4'hF, 4'hF));
		send_word(load_word(32'hFFFFFFFF, 32'h00000000, 21'h100001, 21'h0FFFFF));
		send_word(tick_word(4'h0, 4'h0));
		send_word(load_word(32'h80000000, 32'h7FFFFFFF, 21'h100000, 21'h0FFFFF));
		send_word(tick_word(4'h0, 4'h0));
		drain_results();
	endtask

	// friction on each contact side, including stops that would cross zero
	task automatic test_contact_friction();
		cfg_t c;
		c            = reset_motion_cfg();
		c.friction_x = 300;
		c.friction_y = 500;
		set_motion_cfg(c);
		send_word(load_word(32'd0, 32'd0, 21'd1000, -21'sd1000));
		send_word(tick_word(4'b0001, 4'b0000));
		send_word(tick_word(4'b0000, 4'b0010));
		send_word(tick_word(4'b0100, 4'b0000));
		send_word(tick_word(4'b0000, 4'b1000));
		send_word(load_word(32'd5, 32'd7, 21'd200, -21'sd200));
		send_word(tick_word(4'b0000, 4'b0101));
		send_word(load_word(32'd0, 32'd0, -21'sd1000, 21'd1000));
		send_word(tick_word(4'b1010, 4'b0000));
		drain_results();
	endtask

	// gravity, fall gravity, thrust and terminal clamp, then extreme settings
	task automatic test_gravity_and_thrust();
		cfg_t c;
		c              = reset_motion_cfg();
		c.gravity      = 40;
		c.fall_gravity = 90;
		c.accel_x      = -25;
		c.accel_y      = 15;
		c.terminal_x   = 5000;
		c.terminal_y   = 5000;
		set_motion_cfg(c);
		send_word(load_word(32'd0, 32'd0, 21'd0, 21'd0));
		send_word(tick_word(4'b0000, 4'b0000));
		send_word(tick_word(4'b0000, 4'b0000));
		send_word(tick_word(4'b0010, 4'b0000));
		send_word(tick_word(4'b0100, 4'b0000));
		send_word(load_word(32'd0, 32'd0, 21'd4990, -21'sd4990));
		send_word(tick_word(4'b0000, 4'b0000));
		send_word(load_word(32'd0, 32'd0, -21'sd4999, 21'd4999));
		send_word(tick_word(4'b0000, 4'b0000));
		drain_results();

		c.friction_x   = 20'hFFFFF;
		c.friction_y   = 20'hFFFFF;
		c.gravity      = 21'h100000;
		c.fall_gravity = 21'h100000;
		c.accel_x      = 21'h0FFFFF;
		c.accel_y      = 21'h100000;
		c.terminal_x   = '0;
		c.terminal_y   = 20'hFFFFF;
		set_motion_cfg(c);
		send_word(load_word(32'd0, 32'd0, 21'h0FFFFF, 21'h0FFFFF));
		send_word(tick_word(4'b0001, 4'b0000));
		send_word(tick_word(4'b0000, 4'b0000));
		send_word(tick_word(4'b1000, 4'b0000));
		drain_results();
	endtask

	// random settings per phase, random words, some phases with no idling
	task automatic test_random_motion();
		cfg_t c;
		for (int phase = 0; phase < 8; phase++) begin
			c.friction_x   = pick_u20();
			c.friction_y   = pick_u20();
			c.gravity      = pick_s21();
			c.fall_gravity = pick_s21();
			c.accel_x      = pick_s21();
			c.accel_y      = pick_s21();
			c.terminal_x   = pick_u20();
			c.terminal_y   = pick_u20();
			set_motion_cfg(c);
			no_idle = (phase % 3 == 2);
			repeat (150)
				send_word(random_word());
			drain_results();
		end
		no_idle = 1'b0;
	endtask

	// long hold on the result side while words keep coming, so the input stalls
	task automatic test_result_backpressure();
		no_idle   = 1'b1;
		sink_hold = 80;
		repeat (40)
			send_word(random_word());
		drain_results();
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_FRICTION_X;
		cfg_data          = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_ADVANCE;
		req_ch.plat_sides = '0;
		req_ch.obj_sides  = '0;
		req_ch.load_pos_x = '0;
		req_ch.load_pos_y = '0;
		req_ch.load_vel_x = '0;
		req_ch.load_vel_y = '0;
		motion_cfg        = reset_motion_cfg();
		body_pos_x        = '0;
		body_pos_y        = '0;
		body_vel_x        = 0;
		body_vel_y        = 0;
		mismatches        = 0;
		words_sent        = 0;
		loads_sent        = 0;
		results_checked   = 0;
		settings_applied  = 0;
		no_idle           = 1'b0;
		sink_hold         = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_load_and_wrap();
		test_contact_friction();
		test_gravity_and_thrust();
		test_random_motion();
		test_result_backpressure();

		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d request words (%0d loads) across %0d register settings,",
			words_sent, loads_sent, settings_applied);
		$display("checked %0d result words, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
